### hw/rtl/assert_macros.svh
// Assertion macros used by the top level of the tokenizer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Flag a condition that must never be true while out of reset.
`define ASSERT_NEVER(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
        else $error(msg);

// Flag a consequent that fails in the same cycle as its antecedent.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

`endif

### hw/rtl/itt_pkg.sv
// Types, codes and constant tables shared by the tokenizer modules.
package itt_pkg;

    // Default sizes
    localparam int SYMBOL_KEEP_DEF = 8;
    localparam int CMD_DEPTH_DEF   = 2;
    localparam int OUT_DEPTH_DEF   = 4;

    localparam logic [23:0] LINE_RESET = 24'd1;

    // Token kinds
    localparam logic [4:0] KIND_NUM     = 5'd0;
    localparam logic [4:0] KIND_SYM     = 5'd1;
    localparam logic [4:0] KIND_VAR     = 5'd2;
    localparam logic [4:0] KIND_OP      = 5'd9;
    localparam logic [4:0] KIND_LOGIC   = 5'd10;
    localparam logic [4:0] KIND_ASSIGN  = 5'd11;
    localparam logic [4:0] KIND_LSB     = 5'd12;
    localparam logic [4:0] KIND_RSB     = 5'd13;
    localparam logic [4:0] KIND_COLON   = 5'd14;
    localparam logic [4:0] KIND_COMMENT = 5'd15;
    localparam logic [4:0] KIND_END     = 5'd16;
    localparam logic [4:0] KIND_BAD     = 5'd17;

    // Operator codes
    localparam logic [3:0] OP_ADD = 4'd0;
    localparam logic [3:0] OP_SUB = 4'd1;
    localparam logic [3:0] OP_MUL = 4'd2;
    localparam logic [3:0] OP_DIV = 4'd3;
    localparam logic [3:0] OP_MOD = 4'd4;
    localparam logic [3:0] OP_GT  = 4'd5;
    localparam logic [3:0] OP_GE  = 4'd6;
    localparam logic [3:0] OP_LT  = 4'd7;
    localparam logic [3:0] OP_LE  = 4'd8;
    localparam logic [3:0] OP_EQ  = 4'd9;
    localparam logic [3:0] OP_NE  = 4'd10;
    localparam logic [3:0] OP_NOT = 4'd11;

    // Character codes
    localparam logic [7:0] CH_NL    = 8'h0a;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_STAR  = 8'h2a;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_7     = 8'h37;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_LT    = 8'h3c;
    localparam logic [7:0] CH_EQ    = 8'h3d;
    localparam logic [7:0] CH_GT    = 8'h3e;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_UZ    = 8'h5a;
    localparam logic [7:0] CH_LBR   = 8'h5b;
    localparam logic [7:0] CH_RBR   = 8'h5d;
    localparam logic [7:0] CH_UNDER = 8'h5f;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_LZ    = 8'h7a;

    // Keyword table, first character in the low byte
    localparam int KW_COUNT = 7;
    localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
        64'h0000_0000_0072_6176,  // var
        64'h0000_0000_0064_6e65,  // end
        64'h0000_0000_0000_6669,  // if
        64'h0000_0000_6f74_6f67,  // goto
        64'h0000_6e72_7574_6572,  // return
        64'h0000_0000_6c6c_6163,  // call
        64'h0000_006d_6172_6170   // param
    };
    localparam logic [7:0] KW_LEN [KW_COUNT] = '{
        8'd3, 8'd3, 8'd2, 8'd4, 8'd6, 8'd4, 8'd5
    };

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic [4:0]  token_kind;
        logic [3:0]  op_code;
        logic [31:0] number_value;
        logic [63:0] symbol_text;
        logic [7:0]  symbol_length;
        logic [23:0] line_number;
        logic        last_of_run;
    } out_item_t;

    // Classified character handed from front to back
    typedef struct packed {
        logic       end_of_input;
        logic [7:0] code;
        logic       is_digit;
        logic       is_oct;
        logic       is_hex;
        logic       is_alpha;
        logic       is_space;
        logic       is_newline;
        logic       is_x;
        logic [3:0] hex_val;
    } cmd_t;

    // Queue write strobes: first slot, and a second one behind it
    typedef struct packed {
        logic first;
        logic second;
    } push_t;

endpackage

### hw/rtl/ir_text_tokenizer_core.sv
// Top level of the IR text tokenizer: front end, command queue, lexer and token queue.
//
// The tokenizer takes one character per cycle on the s_ channel and delivers
// tokens on the m_ channel. Characters wait in the command queue and tokens in
// the token queue. The front end keeps accepting a character every cycle as
// long as the command queue has room; the lexer retires one queued character
// per cycle while the token queue has room for two tokens. A character that
// both closes a pending token and forms a token of its own yields two tokens,
// and the token side drains one per cycle while m_ready is high, so a long run
// of such characters settles at the token rate. The end_of_input flag flushes
// a pending token and adds an end token. The user writes the 24-bit first_line
// value through cfg_valid/cfg_data only while the block is idle, which the
// block does not enforce; the value reloads the line counter; reset loads line 1.

`include "assert_macros.svh"

module ir_text_tokenizer_core #(
    parameter int SYMBOL_KEEP_CHARS = itt_pkg::SYMBOL_KEEP_DEF,
    parameter int CMD_DEPTH         = itt_pkg::CMD_DEPTH_DEF,
    parameter int OUT_DEPTH         = itt_pkg::OUT_DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  itt_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output itt_pkg::out_item_t m_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [23:0]        cfg_data
);
    import itt_pkg::*;

    localparam int CLW = $clog2(CMD_DEPTH + 1);
    localparam int OLW = $clog2(OUT_DEPTH + 1);
    localparam int CW  = $bits(cmd_t);
    localparam int OW  = $bits(out_item_t);

    push_t          cmd_push, out_push;
    cmd_t           cmd_in, cmd_out;
    logic [CW-1:0]  cmd_rd;
    logic [CLW-1:0] cmd_level;
    logic [OLW-1:0] out_level;
    logic [OW-1:0]  out_rd;
    logic           cmd_room, cmd_valid, cmd_pop, out_room, out_pop, cfg_wr;
    out_item_t      tok_first, tok_second;

    // Queue status
    assign cmd_room  = (cmd_level != CLW'(CMD_DEPTH));
    assign cmd_valid = (cmd_level != '0);
    assign out_room  = (out_level <= OLW'(OUT_DEPTH - 2));
    assign m_valid   = (out_level != '0);
    assign out_pop   = m_valid && m_ready;
    assign cmd_out   = cmd_t'(cmd_rd);
    assign m_data    = out_item_t'(out_rd);

    // Configuration writes are taken at once
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid;

    itt_front u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .room    (cmd_room),
        .push    (cmd_push),
        .cmd     (cmd_in)
    );

    itt_fifo #(
        .DEPTH (CMD_DEPTH),
        .WIDTH (CW)
    ) u_cmd_q (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (cmd_push),
        .wr_first  (CW'(cmd_in)),
        .wr_second ({CW{1'b0}}),
        .pop       (cmd_pop),
        .rd_data   (cmd_rd),
        .level     (cmd_level)
    );

    itt_back #(
        .SYMBOL_KEEP_CHARS (SYMBOL_KEEP_CHARS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr     (cfg_wr),
        .cfg_line   (cfg_data),
        .cmd        (cmd_out),
        .cmd_valid  (cmd_valid),
        .out_room   (out_room),
        .cmd_pop    (cmd_pop),
        .push       (out_push),
        .tok_first  (tok_first),
        .tok_second (tok_second)
    );

    itt_fifo #(
        .DEPTH (OUT_DEPTH),
        .WIDTH (OW)
    ) u_out_q (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (out_push),
        .wr_first  (OW'(tok_first)),
        .wr_second (OW'(tok_second)),
        .pop       (out_pop),
        .rd_data   (out_rd),
        .level     (out_level)
    );

    // Queues never overflow, and a token pair keeps its run marking
    `ASSERT_NEVER(a_cmd_overflow, aclk, aresetn, cmd_push.first && !cmd_room, "command queue overflow")
    `ASSERT_NEVER(a_out_overflow, aclk, aresetn, out_push.first && !out_room, "token queue overflow")
    `ASSERT_IMPLIES(a_pair_order, aclk, aresetn, out_push.second, out_push.first && !tok_first.last_of_run && tok_second.last_of_run, "token pair marking wrong")

endmodule

### hw/rtl/itt_fifo.sv
// Small register queue that takes up to two entries and gives one per cycle while popped.
module itt_fifo #(
    parameter int DEPTH = 4,
    parameter int WIDTH = 8
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  itt_pkg::push_t               push,
    input  logic [WIDTH-1:0]             wr_first,
    input  logic [WIDTH-1:0]             wr_second,
    input  logic                         pop,
    output logic [WIDTH-1:0]             rd_data,
    output logic [$clog2(DEPTH+1)-1:0]   level
);
    import itt_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wptr_reg, wptr_next;
    logic [AW-1:0]    rptr_reg, rptr_next;
    logic [LW-1:0]    level_reg, level_next;
    logic [AW-1:0]    wptr_plus;

    // Step a pointer, wrapping at the last entry
    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] ptr);
        return (ptr == AW'(DEPTH - 1)) ? '0 : ptr + AW'(1);
    endfunction

    // Advance pointers and fill level
    always_comb begin
        wptr_plus = ptr_inc(wptr_reg);
        priority if (push.second) begin
            wptr_next = ptr_inc(wptr_plus);
        end else if (push.first) begin
            wptr_next = wptr_plus;
        end else begin
            wptr_next = wptr_reg;
        end
        rptr_next  = pop ? ptr_inc(rptr_reg) : rptr_reg;
        level_next = level_reg + LW'(push.first) + LW'(push.second) - LW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            level_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            level_reg <= level_next;
        end
    end

    // Store entries
    always_ff @(posedge aclk) begin
        if (push.first) begin
            mem_reg[wptr_reg] <= wr_first;
        end
        if (push.second) begin
            mem_reg[wptr_plus] <= wr_second;
        end
    end

    assign rd_data = mem_reg[rptr_reg];
    assign level   = level_reg;

endmodule

### hw/rtl/itt_front.sv
// Front end: accept characters and classify them for the lexer.
module itt_front (
    input  logic             s_valid,
    output logic             s_ready,
    input  itt_pkg::in_item_t s_data,
    input  logic             room,
    output itt_pkg::push_t   push,
    output itt_pkg::cmd_t    cmd
);
    import itt_pkg::*;

    logic [7:0] c;
    logic       lower_hex;
    logic       upper_hex;

    assign s_ready = room;

    // Classify the byte
    always_comb begin
        c         = s_data.char_code;
        lower_hex = (c >= CH_LA) && (c <= CH_LF);
        upper_hex = (c >= CH_UA) && (c <= CH_UF);

        cmd.end_of_input = s_data.end_of_input;
        cmd.code         = c;
        cmd.is_digit     = (c >= CH_0) && (c <= CH_9);
        cmd.is_oct       = (c >= CH_0) && (c <= CH_7);
        cmd.is_hex       = cmd.is_digit || lower_hex || upper_hex;
        cmd.is_alpha     = ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ))
                           || (c == CH_UNDER);
        cmd.is_space     = (c <= CH_SPACE) || c[7];
        cmd.is_newline   = (c == CH_NL);
        cmd.is_x         = (c == CH_LX) || (c == CH_UX);
        cmd.hex_val      = cmd.is_digit ? c[3:0] : c[3:0] + 4'd9;
    end

    // Push one entry per accepted transaction
    always_comb begin
        push.first  = s_valid && room;
        push.second = 1'b0;
    end

endmodule

### hw/rtl/itt_back.sv
// Back end: lexer state machine that turns classified characters into tokens.
module itt_back #(
    parameter int SYMBOL_KEEP_CHARS = itt_pkg::SYMBOL_KEEP_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr,
    input  logic [23:0]        cfg_line,
    input  itt_pkg::cmd_t      cmd,
    input  logic               cmd_valid,
    input  logic               out_room,
    output logic               cmd_pop,
    output itt_pkg::push_t     push,
    output itt_pkg::out_item_t tok_first,
    output itt_pkg::out_item_t tok_second
);
    import itt_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DEC     = 4'd1;
    localparam logic [3:0] S_ZERO    = 4'd2;
    localparam logic [3:0] S_OCT     = 4'd3;
    localparam logic [3:0] S_HEX     = 4'd4;
    localparam logic [3:0] S_SYM     = 4'd5;
    localparam logic [3:0] S_GT      = 4'd6;
    localparam logic [3:0] S_LT      = 4'd7;
    localparam logic [3:0] S_EQ      = 4'd8;
    localparam logic [3:0] S_BANG    = 4'd9;
    localparam logic [3:0] S_SLASH   = 4'd10;
    localparam logic [3:0] S_COMMENT = 4'd11;

    logic [3:0]  state_reg, state_next;
    logic [31:0] acc_reg, acc_next;
    logic [63:0] chars_reg, chars_next;
    logic [7:0]  cnt_reg, cnt_next;
    logic [23:0] line_reg, line_next;

    logic        kw_hit;
    logic [2:0]  kw_idx;
    logic        fin_v;
    out_item_t   fin_tok;
    logic        a_v, b_v, absorb, fire;
    out_item_t   tok_a, tok_b;
    logic [31:0] dec_val, oct_val, hex_val;
    logic [31:0] digit;

    function automatic out_item_t make_tok(input logic [4:0] kind, input logic [3:0] op,
                                           input logic [31:0] num, input logic [63:0] text,
                                           input logic [7:0] len, input logic [23:0] line);
        out_item_t t;
        t.token_kind    = kind;
        t.op_code       = op;
        t.number_value  = num;
        t.symbol_text   = text;
        t.symbol_length = len;
        t.line_number   = line;
        t.last_of_run   = 1'b0;
        return t;
    endfunction

    // Match the pending symbol against the keyword table
    always_comb begin
        kw_hit = 1'b0;
        kw_idx = '0;
        for (int i = 0; i < KW_COUNT; i++) begin
            if (!kw_hit && cnt_reg == KW_LEN[i] && chars_reg == KW_TEXT[i]) begin
                kw_hit = 1'b1;
                kw_idx = 3'(i);
            end
        end
    end

    // Token that the pending state gives when it is not continued
    always_comb begin
        fin_v   = 1'b1;
        fin_tok = make_tok(KIND_NUM, OP_ADD, acc_reg, '0, '0, line_reg);
        unique case (state_reg)
            S_DEC, S_ZERO, S_OCT, S_HEX: begin
                fin_tok = make_tok(KIND_NUM, OP_ADD, acc_reg, '0, '0, line_reg);
            end
            S_SYM: begin
                if (kw_hit) begin
                    fin_tok = make_tok(KIND_VAR + 5'(kw_idx), OP_ADD, '0, '0, '0, line_reg);
                end else begin
                    fin_tok = make_tok(KIND_SYM, OP_ADD, '0, chars_reg, cnt_reg, line_reg);
                end
            end
            S_GT:      fin_tok = make_tok(KIND_LOGIC, OP_GT, '0, '0, '0, line_reg);
            S_LT:      fin_tok = make_tok(KIND_LOGIC, OP_LT, '0, '0, '0, line_reg);
            S_EQ:      fin_tok = make_tok(KIND_ASSIGN, OP_ADD, '0, '0, '0, line_reg);
            S_BANG:    fin_tok = make_tok(KIND_OP, OP_NOT, '0, '0, '0, line_reg);
            S_SLASH:   fin_tok = make_tok(KIND_OP, OP_DIV, '0, '0, '0, line_reg);
            S_COMMENT: fin_tok = make_tok(KIND_COMMENT, OP_ADD, '0, '0, '0, line_reg);
            default:   fin_v   = 1'b0;
        endcase
    end

    // Number accumulation candidates
    always_comb begin
        digit   = {28'b0, cmd.hex_val};
        dec_val = (acc_reg << 3) + (acc_reg << 1) + digit;
        oct_val = (acc_reg << 3) + digit;
        hex_val = (acc_reg << 4) + digit;
    end

    // Lexer step for one queued character
    always_comb begin
        fire       = cmd_valid && out_room;
        state_next = state_reg;
        acc_next   = acc_reg;
        chars_next = chars_reg;
        cnt_next   = cnt_reg;
        line_next  = line_reg;
        a_v        = 1'b0;
        b_v        = 1'b0;
        absorb     = 1'b0;
        tok_a      = fin_tok;
        tok_b      = make_tok(KIND_END, OP_ADD, '0, '0, '0, line_reg);

        if (fire) begin
            if (cmd.end_of_input) begin
                // Flush the pending token, then mark end of text
                a_v        = fin_v;
                b_v        = 1'b1;
                state_next = S_IDLE;
            end else begin
                // Try to extend the pending token
                unique case (state_reg)
                    S_DEC: begin
                        if (cmd.is_digit) begin
                            absorb   = 1'b1;
                            acc_next = dec_val;
                        end
                    end
                    S_ZERO: begin
                        if (cmd.is_x) begin
                            absorb     = 1'b1;
                            acc_next   = '0;
                            state_next = S_HEX;
                        end else if (cmd.is_oct) begin
                            absorb     = 1'b1;
                            acc_next   = digit;
                            state_next = S_OCT;
                        end
                    end
                    S_OCT: begin
                        if (cmd.is_oct) begin
                            absorb   = 1'b1;
                            acc_next = oct_val;
                        end
                    end
                    S_HEX: begin
                        if (cmd.is_hex) begin
                            absorb   = 1'b1;
                            acc_next = hex_val;
                        end
                    end
                    S_SYM: begin
                        if (cmd.is_alpha || cmd.is_digit) begin
                            absorb = 1'b1;
                            for (int b = 0; b < 8; b++) begin
                                if (cnt_reg == 8'(b) &&
                                    cnt_reg < 8'(SYMBOL_KEEP_CHARS)) begin
                                    chars_next[8*b +: 8] = cmd.code;
                                end
                            end
                            if (cnt_reg != 8'hff) begin
                                cnt_next = cnt_reg + 8'd1;
                            end
                        end
                    end
                    S_GT, S_LT, S_EQ, S_BANG: begin
                        if (cmd.code == CH_EQ) begin
                            absorb     = 1'b1;
                            a_v        = 1'b1;
                            state_next = S_IDLE;
                            priority if (state_reg == S_GT) begin
                                tok_a = make_tok(KIND_LOGIC, OP_GE, '0, '0, '0, line_reg);
                            end else if (state_reg == S_LT) begin
                                tok_a = make_tok(KIND_LOGIC, OP_LE, '0, '0, '0, line_reg);
                            end else if (state_reg == S_EQ) begin
                                tok_a = make_tok(KIND_LOGIC, OP_EQ, '0, '0, '0, line_reg);
                            end else begin
                                tok_a = make_tok(KIND_LOGIC, OP_NE, '0, '0, '0, line_reg);
                            end
                        end
                    end
                    S_SLASH: begin
                        if (cmd.code == CH_SLASH) begin
                            absorb     = 1'b1;
                            state_next = S_COMMENT;
                        end
                    end
                    S_COMMENT: begin
                        absorb = !cmd.is_newline;
                    end
                    default: begin
                        absorb = 1'b0;
                    end
                endcase

                // Close the pending token and start a new one
                if (!absorb) begin
                    a_v        = fin_v;
                    state_next = S_IDLE;
                    priority if (cmd.is_digit) begin
                        acc_next   = digit;
                        state_next = (cmd.code == CH_0) ? S_ZERO : S_DEC;
                    end else if (cmd.is_alpha) begin
                        chars_next = {56'b0, cmd.code};
                        cnt_next   = 8'd1;
                        state_next = S_SYM;
                    end else if (cmd.is_space) begin
                        if (cmd.is_newline) begin
                            line_next = line_reg + 24'd1;
                        end
                    end else begin
                        b_v = 1'b1;
                        unique case (cmd.code)
                            CH_PLUS:  tok_b = make_tok(KIND_OP, OP_ADD, '0, '0, '0, line_reg);
                            CH_MINUS: tok_b = make_tok(KIND_OP, OP_SUB, '0, '0, '0, line_reg);
                            CH_STAR:  tok_b = make_tok(KIND_OP, OP_MUL, '0, '0, '0, line_reg);
                            CH_PCT:   tok_b = make_tok(KIND_OP, OP_MOD, '0, '0, '0, line_reg);
                            CH_SLASH: begin
                                b_v        = 1'b0;
                                state_next = S_SLASH;
                            end
                            CH_GT: begin
                                b_v        = 1'b0;
                                state_next = S_GT;
                            end
                            CH_LT: begin
                                b_v        = 1'b0;
                                state_next = S_LT;
                            end
                            CH_EQ: begin
                                b_v        = 1'b0;
                                state_next = S_EQ;
                            end
                            CH_BANG: begin
                                b_v        = 1'b0;
                                state_next = S_BANG;
                            end
                            CH_LBR:   tok_b = make_tok(KIND_LSB, OP_ADD, '0, '0, '0, line_reg);
                            CH_RBR:   tok_b = make_tok(KIND_RSB, OP_ADD, '0, '0, '0, line_reg);
                            CH_COLON: tok_b = make_tok(KIND_COLON, OP_ADD, '0, '0, '0, line_reg);
                            default:  tok_b = make_tok(KIND_BAD, OP_ADD, '0, '0, '0, line_reg);
                        endcase
                    end
                end
            end
        end

        // Load the line counter from the configuration register
        if (cfg_wr) begin
            line_next = cfg_line;
        end
    end

    // Pack the results in order and mark the last one
    always_comb begin
        cmd_pop                = fire;
        push.first             = a_v || b_v;
        push.second            = a_v && b_v;
        tok_first              = a_v ? tok_a : tok_b;
        tok_first.last_of_run  = !(a_v && b_v);
        tok_second             = tok_b;
        tok_second.last_of_run = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            acc_reg   <= '0;
            chars_reg <= '0;
            cnt_reg   <= '0;
            line_reg  <= LINE_RESET;
        end else begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
            chars_reg <= chars_next;
            cnt_reg   <= cnt_next;
            line_reg  <= line_next;
        end
    end

endmodule

### verif/token_stream_monitor.sv
// Token stream monitor: predicts the tokenizer's tokens from accepted characters and checks them.
`timescale 1ns / 100ps

module token_stream_monitor (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  itt_pkg::in_item_t  s_data,
    input  logic               m_valid,
    input  logic               m_ready,
    input  itt_pkg::out_item_t m_data,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [23:0]        cfg_data,
    output int                 fail_count,
    output int                 pending,
    output int                 token_count
);
    import itt_pkg::*;

    // Lexer state codes
    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_DEC     = 4'd1;
    localparam logic [3:0] ST_ZERO    = 4'd2;
    localparam logic [3:0] ST_OCT     = 4'd3;
    localparam logic [3:0] ST_HEX     = 4'd4;
    localparam logic [3:0] ST_SYM     = 4'd5;
    localparam logic [3:0] ST_GT      = 4'd6;
    localparam logic [3:0] ST_LT      = 4'd7;
    localparam logic [3:0] ST_EQ      = 4'd8;
    localparam logic [3:0] ST_BANG    = 4'd9;
    localparam logic [3:0] ST_SLASH   = 4'd10;
    localparam logic [3:0] ST_COMMENT = 4'd11;

    // Predicted lexer state
    logic [3:0]  lex_state;
    logic [31:0] number_accum;
    logic [63:0] symbol_chars;
    logic [7:0]  symbol_count;
    logic [23:0] line_count;

    // Tokens produced by one character, and tokens still owed by the block
    out_item_t step_tok [2];
    int        step_n;
    out_item_t tokens_due [$];

    function automatic bit char_is_digit(logic [7:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    function automatic bit char_is_alpha(logic [7:0] c);
        return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ) || c == CH_UNDER;
    endfunction

    function automatic int hex_digit_value(logic [7:0] c);
        if (char_is_digit(c)) return c - CH_0;
        if (c >= CH_LA && c <= CH_LF) return c - CH_LA + 10;
        if (c >= CH_UA && c <= CH_UF) return c - CH_UA + 10;
        return -1;
    endfunction

    function automatic void add_token(logic [4:0] kind, logic [3:0] op, logic [31:0] num,
                                      logic [63:0] text, logic [7:0] len);
        out_item_t t;
        t               = '0;
        t.token_kind    = kind;
        t.op_code       = op;
        t.number_value  = num;
        t.symbol_text   = text;
        t.symbol_length = len;
        t.line_number   = line_count;
        if (step_n < 2) begin
            step_tok[step_n] = t;
            step_n++;
        end
    endfunction

    // Emit whatever token the pending state holds, then go idle
    function automatic void close_token();
        int kw;
        int i;
        unique case (lex_state)
            ST_DEC, ST_ZERO, ST_OCT, ST_HEX: add_token(KIND_NUM, 0, number_accum, 0, 0);
            ST_SYM: begin
                kw = -1;
                for (i = 0; i < KW_COUNT; i++) begin
                    if (kw < 0 && symbol_count == KW_LEN[i] && symbol_chars == KW_TEXT[i])
                        kw = i;
                end
                if (kw >= 0)
                    add_token(KIND_VAR + kw[4:0], 0, 0, 0, 0);
                else
                    add_token(KIND_SYM, 0, 0, symbol_chars, symbol_count);
            end
            ST_GT:      add_token(KIND_LOGIC, OP_GT, 0, 0, 0);
            ST_LT:      add_token(KIND_LOGIC, OP_LT, 0, 0, 0);
            ST_EQ:      add_token(KIND_ASSIGN, 0, 0, 0, 0);
            ST_BANG:    add_token(KIND_OP, OP_NOT, 0, 0, 0);
            ST_SLASH:   add_token(KIND_OP, OP_DIV, 0, 0, 0);
            ST_COMMENT: add_token(KIND_COMMENT, 0, 0, 0, 0);
            default: ;
        endcase
        lex_state = ST_IDLE;
    endfunction

    // Try to extend the pending token; return 1 if the character was absorbed
    function automatic bit absorb_char(logic [7:0] c);
        int h;
        h = hex_digit_value(c);
        unique case (lex_state)
            ST_DEC: begin
                if (!char_is_digit(c)) return 1'b0;
                number_accum = number_accum * 10 + (c - CH_0);
                return 1'b1;
            end
            ST_ZERO: begin
                if (c == CH_LX || c == CH_UX) begin
                    lex_state    = ST_HEX;
                    number_accum = '0;
                    return 1'b1;
                end
                if (c < CH_0 || c > CH_7) return 1'b0;
                number_accum = c - CH_0;
                lex_state    = ST_OCT;
                return 1'b1;
            end
            ST_OCT: begin
                if (c < CH_0 || c > CH_7) return 1'b0;
                number_accum = number_accum * 8 + (c - CH_0);
                return 1'b1;
            end
            ST_HEX: begin
                if (h < 0) return 1'b0;
                number_accum = number_accum * 16 + h;
                return 1'b1;
            end
            ST_SYM: begin
                if (!char_is_alpha(c) && !char_is_digit(c)) return 1'b0;
                if (symbol_count < SYMBOL_KEEP_DEF)
                    symbol_chars[8*symbol_count +: 8] = c;
                if (symbol_count != 8'hff) symbol_count++;
                return 1'b1;
            end
            ST_GT, ST_LT, ST_EQ, ST_BANG: begin
                if (c != CH_EQ) return 1'b0;
                unique case (lex_state)
                    ST_GT:   add_token(KIND_LOGIC, OP_GE, 0, 0, 0);
                    ST_LT:   add_token(KIND_LOGIC, OP_LE, 0, 0, 0);
                    ST_EQ:   add_token(KIND_LOGIC, OP_EQ, 0, 0, 0);
                    default: add_token(KIND_LOGIC, OP_NE, 0, 0, 0);
                endcase
                lex_state = ST_IDLE;
                return 1'b1;
            end
            ST_SLASH: begin
                if (c != CH_SLASH) return 1'b0;
                lex_state = ST_COMMENT;
                return 1'b1;
            end
            ST_COMMENT: return c != CH_NL;
            default:    return 1'b0;
        endcase
    endfunction

    // Start a new token from an idle lexer
    function automatic void open_char(logic [7:0] c);
        if (char_is_digit(c)) begin
            number_accum = c - CH_0;
            if (c == CH_0)
                lex_state = ST_ZERO;
            else
                lex_state = ST_DEC;
        end else if (char_is_alpha(c)) begin
            symbol_chars = {56'd0, c};
            symbol_count = 8'd1;
            lex_state    = ST_SYM;
        end else if (c <= CH_SPACE || c[7]) begin
            if (c == CH_NL) line_count++;
        end else begin
            unique case (c)
                CH_PLUS:  add_token(KIND_OP, OP_ADD, 0, 0, 0);
                CH_MINUS: add_token(KIND_OP, OP_SUB, 0, 0, 0);
                CH_STAR:  add_token(KIND_OP, OP_MUL, 0, 0, 0);
                CH_PCT:   add_token(KIND_OP, OP_MOD, 0, 0, 0);
                CH_SLASH: lex_state = ST_SLASH;
                CH_GT:    lex_state = ST_GT;
                CH_LT:    lex_state = ST_LT;
                CH_EQ:    lex_state = ST_EQ;
                CH_BANG:  lex_state = ST_BANG;
                CH_LBR:   add_token(KIND_LSB, 0, 0, 0, 0);
                CH_RBR:   add_token(KIND_RSB, 0, 0, 0, 0);
                CH_COLON: add_token(KIND_COLON, 0, 0, 0, 0);
                default:  add_token(KIND_BAD, 0, 0, 0, 0);
            endcase
        end
    endfunction

    // Predict the tokens for one accepted character and queue them
    function automatic void tokenize_item(in_item_t item);
        int i;
        step_n = 0;
        if (item.end_of_input) begin
            close_token();
            add_token(KIND_END, 0, 0, 0, 0);
        end else if (!absorb_char(item.char_code)) begin
            close_token();
            open_char(item.char_code);
        end
        if (step_n > 0) step_tok[step_n-1].last_of_run = 1'b1;
        for (i = 0; i < step_n; i++) tokens_due.push_back(step_tok[i]);
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            fail_count++;
            $display("%0t: token %0d %s mismatch: expected %0h, actual %0h",
                     $time, token_count, name, want, got);
        end
    endfunction

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            lex_state    = ST_IDLE;
            number_accum = '0;
            symbol_chars = '0;
            symbol_count = '0;
            line_count   = LINE_RESET;
            tokens_due.delete();
        end else begin
            // A first_line write reloads the line counter
            if (cfg_valid && cfg_ready) line_count = cfg_data;
            if (s_valid && s_ready) tokenize_item(s_data);
            // Compare each delivered transaction with the oldest prediction
            if (m_valid && m_ready) begin
                token_count++;
                if (tokens_due.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected token: expected none, actual %h",
                             $time, m_data);
                end else begin
                    want = tokens_due.pop_front();
                    check_field("token_kind", want.token_kind, m_data.token_kind);
                    check_field("op_code", want.op_code, m_data.op_code);
                    check_field("number_value", want.number_value, m_data.number_value);
                    check_field("symbol_text", want.symbol_text, m_data.symbol_text);
                    check_field("symbol_length", want.symbol_length, m_data.symbol_length);
                    check_field("line_number", want.line_number, m_data.line_number);
                    check_field("last_of_run", want.last_of_run, m_data.last_of_run);
                end
            end
        end
        pending = tokens_due.size();
    end

endmodule

### verif/ir_text_tokenizer_core_tb.sv
// Testbench top for the IR text tokenizer: clock, reset, character stimulus and verdict.
`timescale 1ns / 100ps

module ir_text_tokenizer_core_tb;
    import itt_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 330;

    // Character codes the package does not name
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_8    = 8'h38;
    localparam logic [7:0] CH_DEL  = 8'h7f;
    localparam logic [7:0] CH_HIGH = 8'h80;
    localparam logic [7:0] CH_FF   = 8'hff;
    localparam logic [7:0] CH_NUL  = 8'h00;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    in_item_t    s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    out_item_t   m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [23:0] cfg_data  = '0;

    int fail_count;
    int pending;
    int token_count;
    int send_idle   = 0;
    int recv_stall  = 0;
    int items_sent  = 0;
    int cycle_count = 0;

    string keywords [7]  = '{"var", "end", "if", "goto", "return", "call", "param"};
    string operators [13] = '{"+", "-", "*", "/", "%", ">", ">=", "<", "<=", "=", "==",
                              "!", "!="};
    string bad_chars     = "\"#$&'(),.;?@\\^{|}~";

    ir_text_tokenizer_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    token_stream_monitor token_mon (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .pending     (pending),
        .token_count (token_count)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Stall the token channel at the current rate
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall);
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d tokens outstanding",
                     $time, cycle_count, pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Offer one transaction, with random idle cycles ahead of it
    task automatic send_item(input in_item_t item);
        while ($urandom_range(0, 99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic send_char(input logic [7:0] c);
        send_item({c, 1'b0});
    endtask

    task automatic send_end();
        logic [7:0] c;
        c = $urandom_range(0, 255);
        send_item({c, 1'b1});
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) send_char(s[i]);
    endtask

    function automatic logic [7:0] random_alpha();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26) return CH_LA + r;
        if (r < 52) return CH_UA + r - 26;
        return CH_UNDER;
    endfunction

    function automatic logic [7:0] random_digit();
        return CH_0 + $urandom_range(0, 9);
    endfunction

    function automatic logic [7:0] random_hex();
        int r;
        r = $urandom_range(0, 21);
        if (r < 10) return CH_0 + r;
        if (r < 16) return CH_LA + r - 10;
        return CH_UA + r - 16;
    endfunction

    function automatic logic [7:0] random_space();
        case ($urandom_range(0, 4))
            0:       return CH_SPACE;
            1:       return CH_NL;
            2:       return CH_TAB;
            3:       return $urandom_range(0, CH_SPACE);
            default: return CH_HIGH + $urandom_range(0, 127);
        endcase
    endfunction

    // Send one mostly well-formed lexeme, sometimes noise, then maybe a separator
    task automatic send_fragment();
        int pick;
        int n;
        int i;
        string kw;
        logic [7:0] c;
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 6);
            send_char(random_alpha());
            for (i = 1; i < n; i++)
                send_char(($urandom_range(0, 3) == 0) ? random_digit() : random_alpha());
        end else if (pick < 30) begin
            kw = keywords[$urandom_range(0, 6)];
            case ($urandom_range(0, 5))
                0:       send_text({kw, "x"});
                1:       send_text(kw.substr(0, kw.len() - 2));
                default: send_text(kw);
            endcase
        end else if (pick < 45) begin
            case ($urandom_range(0, 5))
                0: begin
                    send_char(CH_0 + $urandom_range(1, 9));
                    n = $urandom_range(0, 11);
                    for (i = 0; i < n; i++) send_char(random_digit());
                end
                1: begin
                    send_char(CH_0);
                    n = $urandom_range(1, 12);
                    for (i = 0; i < n; i++) send_char(CH_0 + $urandom_range(0, 7));
                end
                2: begin
                    send_char(CH_0);
                    send_char($urandom_range(0, 1) ? CH_LX : CH_UX);
                    n = $urandom_range(1, 10);
                    for (i = 0; i < n; i++) send_char(random_hex());
                end
                3: begin
                    send_char(CH_0);
                    send_char($urandom_range(0, 1) ? CH_LX : CH_UX);
                end
                4: begin
                    send_char(CH_0);
                    send_char($urandom_range(0, 1) ? CH_8 : CH_9);
                end
                default: send_char(CH_0);
            endcase
        end else if (pick < 65) begin
            send_text(operators[$urandom_range(0, 12)]);
        end else if (pick < 72) begin
            case ($urandom_range(0, 2))
                0:       send_char(CH_LBR);
                1:       send_char(CH_RBR);
                default: send_char(CH_COLON);
            endcase
        end else if (pick < 78) begin
            send_text("//");
            n = $urandom_range(0, 10);
            for (i = 0; i < n; i++) begin
                c = $urandom_range(0, 255);
                if (c == CH_NL) c = CH_SPACE;
                send_char(c);
            end
            if ($urandom_range(0, 4) != 0) send_char(CH_NL);
        end else if (pick < 86) begin
            if ($urandom_range(0, 9) == 0)
                send_char(CH_DEL);
            else
                send_char(bad_chars[$urandom_range(0, bad_chars.len() - 1)]);
        end else if (pick < 94) begin
            send_char($urandom_range(0, 255));
        end else if (pick < 97) begin
            send_end();
        end else begin
            send_char(random_space());
        end
        // Adjacent lexemes let one character close a token and form another
        if ($urandom_range(0, 1)) send_char(random_space());
    endtask

    // Drop valid and wait until every predicted token has been delivered
    task automatic settle();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_first_line(input logic [23:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int target);
        int start;
        start = items_sent;
        while (items_sent - start < target) send_fragment();
        send_end();
        settle();
    endtask

    initial begin
        int i;
        int n;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: number forms, paired operators, comment, bad byte, byte extremes
        send_text("0x1F>=07<=08!=ab//c\n@:if 0x]");
        send_char(CH_FF);
        send_char(CH_NUL);
        send_end();
        settle();

        // No idling, line count not reloaded since reset
        run_phase(PHASE_ITEMS);

        // Sender idling, line count at the top so the first newline wraps
        write_first_line(24'hffffff);
        send_idle = 48;
        run_phase(PHASE_ITEMS);

        // Receiver stalling, line count from zero, plus a symbol past the length limit
        write_first_line(24'h000000);
        send_idle  = 0;
        recv_stall = 48;
        n = $urandom_range(260, 300);
        send_char(random_alpha());
        for (i = 1; i < n; i++) send_char(($urandom_range(0, 3) == 0) ? random_digit()
                                                                     : random_alpha());
        send_char(CH_SPACE);
        run_phase(PHASE_ITEMS);

        // Both sides idling, random start line
        write_first_line(24'($urandom_range(0, 24'hffffff)));
        send_idle  = 13;
        recv_stall = 13;
        run_phase(PHASE_ITEMS);

        if (pending != 0)
            $display("%0t: %0d predicted tokens never arrived", $time, pending);
        $display("Sent %0d characters in four idle/stall phases, first_line reset,",
                 items_sent);
        $display("max, 0, random; compared %0d tokens, %0d mismatches.",
                 token_count, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
